// ===== rtl/cdt_pkg.sv =====
// Shared types, codes and time arithmetic functions for the countdown timer controller.
package cdt_pkg;

	localparam int HOURS_MODULUS = 24;
	localparam int MINUTES_MODULUS = 60;
	localparam int SECONDS_MODULUS = 60;
	localparam int NUM_FIELDS = 3;

	localparam int HOURS_W = 5;
	localparam int MINUTES_W = 6;
	localparam int SECONDS_W = 6;

	typedef enum logic [1:0] {
		MODE_RESET   = 2'd0,
		MODE_SETTING = 2'd1,
		MODE_RUNNING = 2'd2,
		MODE_PAUSED  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		RATE_1HZ = 2'd0,
		RATE_4HZ = 2'd1,
		RATE_8HZ = 2'd2
	} rate_t;

	typedef enum logic [2:0] {
		OP_TICK       = 3'd0,
		OP_LIGHT_UP   = 3'd1,
		OP_ALARM_UP   = 3'd2,
		OP_ALARM_LONG = 3'd3,
		OP_LIGHT_LONG = 3'd4,
		OP_ALARM_LUP  = 3'd5,
		OP_ACTIVATE   = 3'd6,
		OP_LEAVE      = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		FIELD_HOURS   = 2'd0,
		FIELD_MINUTES = 2'd1,
		FIELD_SECONDS = 2'd2,
		FIELD_NONE    = 2'd3
	} field_t;

	typedef struct packed {
		logic [HOURS_W-1:0]   hours;
		logic [MINUTES_W-1:0] minutes;
		logic [SECONDS_W-1:0] seconds;
	} time_t;

	typedef struct packed {
		time_t      cur;
		mode_t      mode;
		logic [1:0] blank_field;
		logic       alarm_pulse;
		logic       beep_pulse;
		logic       light_pulse;
		logic       repeat_on;
		logic       running_flag;
		rate_t      tick_rate;
	} status_t;

	function automatic logic time_is_zero(time_t t);
		return (t.hours == '0) && (t.minutes == '0) && (t.seconds == '0);
	endfunction

	function automatic time_t bump_time(time_t t, field_t f);
		time_t r;
		r = t;
		case (f)
			FIELD_HOURS: begin
				if (t.hours == HOURS_W'(HOURS_MODULUS - 1))
					r.hours = '0;
				else
					r.hours = t.hours + HOURS_W'(1);
			end
			FIELD_MINUTES: begin
				if (t.minutes == MINUTES_W'(MINUTES_MODULUS - 1))
					r.minutes = '0;
				else
					r.minutes = t.minutes + MINUTES_W'(1);
			end
			FIELD_SECONDS: begin
				if (t.seconds == SECONDS_W'(SECONDS_MODULUS - 1))
					r.seconds = '0;
				else
					r.seconds = t.seconds + SECONDS_W'(1);
			end
			default: r = t;
		endcase
		return r;
	endfunction

	function automatic time_t count_down(time_t t);
		time_t r;
		r = t;
		if (t.seconds != '0) begin
			r.seconds = t.seconds - SECONDS_W'(1);
		end else begin
			r.seconds = SECONDS_W'(SECONDS_MODULUS - 1);
			if (t.minutes != '0) begin
				r.minutes = t.minutes - MINUTES_W'(1);
			end else begin
				r.minutes = MINUTES_W'(MINUTES_MODULUS - 1);
				if (t.hours != '0)
					r.hours = t.hours - HOURS_W'(1);
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/countdown_timer_controller.sv =====
// Top level of the countdown timer controller: input register, timer core and result register.
// Each input word carries one event (tick, button press or release, activate, leave) and
// produces exactly one result word with the time, mode and pulse flags after that event.
// Input channel: in_valid, in_stall, opcode, alarm_held, subsecond_odd. A word is taken
// at a clock edge where in_valid is high and in_stall is low.
// Output channel: out_valid, out_stall and the status fields. A word is delivered at an
// edge where out_valid is high and out_stall is low.
// Configuration: cfg_valid, cfg_ready, cfg_data write the beep enable bit; cfg_ready is
// always high. Write it only while no word is in flight.
// A word is first held in the input register; when it advances, the timer core updates its
// state and loads the result register, which raises out_valid.
// Throughput is one word per cycle while out_stall is low; the timer core holds all state in a single level of
// registers, so back-to-back events are handled without gaps.
// When the receiver stalls, the result register holds its word and the input register
// keeps one more word; in_stall rises only when both are full.
// Reset clears both registers and returns the timer to reset mode with 0:03:00 current
// and stored, repeat and fast increment off, one hertz rate and beeps enabled.
module countdown_timer_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [2:0]                     opcode,
	input  logic                           alarm_held,
	input  logic                           subsecond_odd,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [cdt_pkg::HOURS_W-1:0]    hours,
	output logic [cdt_pkg::MINUTES_W-1:0]  minutes,
	output logic [cdt_pkg::SECONDS_W-1:0]  seconds,
	output logic [1:0]                     mode_now,
	output logic [1:0]                     blank_field,
	output logic                           alarm_pulse,
	output logic                           beep_pulse,
	output logic                           light_pulse,
	output logic                           repeat_on,
	output logic                           running_flag,
	output logic [1:0]                     tick_rate,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_data
);

	logic              valid_s1;
	logic [2:0]        opcode_s1;
	logic              held_s1;
	logic              odd_s1;
	logic              out_valid_q;
	cdt_pkg::status_t  status_q;
	cdt_pkg::status_t  status;
	logic              beep_enable_q;
	logic              advance;
	logic              take;

	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			opcode_s1 <= opcode;
			held_s1 <= alarm_held;
			odd_s1 <= subsecond_odd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beep_enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			beep_enable_q <= cfg_data;
		end
	end

	cdt_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.opcode        (opcode_s1),
		.alarm_held    (held_s1),
		.subsecond_odd (odd_s1),
		.beep_enable   (beep_enable_q),
		.status        (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status;
		end
	end

	assign out_valid = out_valid_q;
	assign hours = status_q.cur.hours;
	assign minutes = status_q.cur.minutes;
	assign seconds = status_q.cur.seconds;
	assign mode_now = status_q.mode;
	assign blank_field = status_q.blank_field;
	assign alarm_pulse = status_q.alarm_pulse;
	assign beep_pulse = status_q.beep_pulse;
	assign light_pulse = status_q.light_pulse;
	assign repeat_on = status_q.repeat_on;
	assign running_flag = status_q.running_flag;
	assign tick_rate = status_q.tick_rate;

endmodule

// ===== rtl/cdt_core.sv =====
// Timer state registers and the per-event update and status logic.
module cdt_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [2:0]          opcode,
	input  logic                alarm_held,
	input  logic                subsecond_odd,
	input  logic                beep_enable,
	output cdt_pkg::status_t    status
);

	cdt_pkg::mode_t  mode_q, mode_d;
	cdt_pkg::field_t field_q, field_d;
	cdt_pkg::time_t  cur_q, cur_d;
	cdt_pkg::time_t  saved_q, saved_d;
	logic            repeat_q, repeat_d;
	logic            fast_q, fast_d;
	cdt_pkg::rate_t  rate_q, rate_d;
	logic            alarm_d, beep_d, light_d;

	cdt_pkg::op_t    op;
	cdt_pkg::time_t  t_tick;
	cdt_pkg::time_t  t_down;
	cdt_pkg::field_t field_next;
	logic            hit;
	cdt_pkg::rate_t  abort_rate;

	assign op = cdt_pkg::op_t'(opcode);
	assign t_tick = (fast_q && alarm_held) ? cdt_pkg::bump_time(cur_q, field_q) : cur_q;
	assign t_down = cdt_pkg::count_down(t_tick);
	assign hit = cdt_pkg::time_is_zero(t_tick) || cdt_pkg::time_is_zero(t_down);
	assign field_next = cdt_pkg::field_t'(2'(field_q + 2'd1));
	assign abort_rate = (mode_q == cdt_pkg::MODE_SETTING) ? cdt_pkg::RATE_4HZ
		: cdt_pkg::RATE_1HZ;

	// Next state for one event.
	always_comb begin
		mode_d = mode_q;
		field_d = field_q;
		cur_d = cur_q;
		saved_d = saved_q;
		repeat_d = repeat_q;
		fast_d = fast_q;
		rate_d = rate_q;
		alarm_d = 1'b0;
		beep_d = 1'b0;
		light_d = 1'b0;
		unique case (op)
			cdt_pkg::OP_TICK: begin
				if (fast_q && !alarm_held) begin
					fast_d = 1'b0;
					rate_d = abort_rate;
				end
				cur_d = t_tick;
				if (mode_q == cdt_pkg::MODE_RUNNING) begin
					if (hit) begin
						alarm_d = 1'b1;
						cur_d = saved_q;
						if (!repeat_q)
							mode_d = cdt_pkg::MODE_RESET;
					end else begin
						cur_d = t_down;
					end
				end
			end
			cdt_pkg::OP_LIGHT_UP: begin
				unique case (mode_q)
					cdt_pkg::MODE_RUNNING: light_d = 1'b1;
					cdt_pkg::MODE_PAUSED: begin
						mode_d = cdt_pkg::MODE_RESET;
						cur_d = saved_q;
						beep_d = 1'b1;
					end
					cdt_pkg::MODE_RESET: begin
						mode_d = cdt_pkg::MODE_SETTING;
						rate_d = cdt_pkg::RATE_4HZ;
						beep_d = 1'b1;
					end
					default: begin
						field_d = field_next;
						if (field_next == cdt_pkg::FIELD_NONE) begin
							field_d = cdt_pkg::FIELD_HOURS;
							mode_d = cdt_pkg::MODE_RESET;
							saved_d = cur_q;
							rate_d = cdt_pkg::RATE_1HZ;
							beep_d = 1'b1;
						end
					end
				endcase
			end
			cdt_pkg::OP_ALARM_UP: begin
				if (mode_q == cdt_pkg::MODE_RUNNING) begin
					mode_d = cdt_pkg::MODE_PAUSED;
					beep_d = 1'b1;
				end else if (mode_q == cdt_pkg::MODE_SETTING) begin
					cur_d = cdt_pkg::bump_time(cur_q, field_q);
				end else if (!cdt_pkg::time_is_zero(cur_q)) begin
					mode_d = cdt_pkg::MODE_RUNNING;
					beep_d = 1'b1;
				end
			end
			cdt_pkg::OP_ALARM_LONG: begin
				if (mode_q == cdt_pkg::MODE_SETTING) begin
					fast_d = 1'b1;
					rate_d = cdt_pkg::RATE_8HZ;
				end else begin
					beep_d = 1'b1;
					repeat_d = !repeat_q;
				end
			end
			cdt_pkg::OP_LIGHT_LONG: begin
				if (mode_q == cdt_pkg::MODE_SETTING) begin
					if (field_q == cdt_pkg::FIELD_HOURS)
						cur_d.hours = '0;
					if (field_q == cdt_pkg::FIELD_HOURS || field_q == cdt_pkg::FIELD_MINUTES)
						cur_d.minutes = '0;
					if (field_q != cdt_pkg::FIELD_NONE)
						cur_d.seconds = '0;
				end
			end
			cdt_pkg::OP_ALARM_LUP: begin
				if (fast_q) begin
					fast_d = 1'b0;
					rate_d = abort_rate;
				end
			end
			cdt_pkg::OP_ACTIVATE: begin
				rate_d = cdt_pkg::RATE_1HZ;
				fast_d = 1'b0;
			end
			default: begin
				if (fast_q) begin
					fast_d = 1'b0;
					rate_d = abort_rate;
				end
				if (mode_q == cdt_pkg::MODE_SETTING) begin
					field_d = cdt_pkg::FIELD_HOURS;
					mode_d = cdt_pkg::MODE_RESET;
					saved_d = cur_q;
				end
			end
		endcase
	end

	// Status word reflects the state after the event.
	always_comb begin
		status.cur = cur_d;
		status.mode = mode_d;
		status.blank_field = 2'd0;
		if (mode_d == cdt_pkg::MODE_SETTING && !fast_d && subsecond_odd
			&& field_d != cdt_pkg::FIELD_NONE)
			status.blank_field = 2'(field_d + 2'd1);
		status.alarm_pulse = alarm_d;
		status.beep_pulse = beep_d & beep_enable;
		status.light_pulse = light_d;
		status.repeat_on = repeat_d;
		status.running_flag = (mode_d == cdt_pkg::MODE_RUNNING);
		status.tick_rate = rate_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= cdt_pkg::MODE_RESET;
			field_q <= cdt_pkg::FIELD_HOURS;
			cur_q <= '{hours: '0, minutes: cdt_pkg::MINUTES_W'(3), seconds: '0};
			saved_q <= '{hours: '0, minutes: cdt_pkg::MINUTES_W'(3), seconds: '0};
			repeat_q <= 1'b0;
			fast_q <= 1'b0;
			rate_q <= cdt_pkg::RATE_1HZ;
		end else if (step) begin
			mode_q <= mode_d;
			field_q <= field_d;
			cur_q <= cur_d;
			saved_q <= saved_d;
			repeat_q <= repeat_d;
			fast_q <= fast_d;
			rate_q <= rate_d;
		end
	end

endmodule
